FILE: src/kfc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// KISS frame checker package
// Shared constants, types and the byte-wide CRC-32 update.
// ---------------------------------------------------------------------------
package kfc_pkg;

  localparam int          BUF_DEPTH_DEF = 256;
  localparam int          MIN_FRAME     = 10;
  localparam int          PLEN_W        = 8;
  localparam logic [7:0]  KISS_FEND     = 8'hC0;
  localparam logic [7:0]  KISS_FESC     = 8'hDB;
  localparam logic [7:0]  KISS_TFEND    = 8'hDC;
  localparam logic [7:0]  KISS_TFESC    = 8'hDD;
  localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT      = 32'hFFFFFFFF;
  localparam logic [31:0] MAGIC_RESET   = 32'h44564F70;
  localparam int          ADDR_W        = 3;

  typedef enum logic [0:0] {
    REG_MAGIC = 1'b0
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_VALID     = 2'd0,
    ST_CRC_ERR   = 2'd1,
    ST_BAD_MAGIC = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef struct packed {
    status_t             status;
    logic [15:0]         received_seq;
    logic [15:0]         expected_seq;
    logic [PLEN_W-1:0]   payload_length;
    logic [31:0]         computed_crc;
    logic [31:0]         received_crc;
  } result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: src/kfc_cfg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// KISS frame checker register port
// APB-style register file holding the expected magic word.
// ---------------------------------------------------------------------------
module kfc_cfg
  import kfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [31:0]       magic_word
);

  logic [31:0] magic_r;
  logic [31:0] magic_nxt;
  reg_idx_t    idx;
  logic        hit;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1]);
  assign hit    = (paddr[1:0] == 2'b00);
  assign pready = 1'b1;

  always_comb begin
    magic_nxt = magic_r;
    if (psel && penable && pwrite && pready && hit) begin
      unique case (idx)
        REG_MAGIC: magic_nxt = pwdata;
        default:   magic_nxt = magic_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MAGIC: prdata = hit ? magic_r : 32'd0;
      default:   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= MAGIC_RESET;
    end else begin
      magic_r <= magic_nxt;
    end
  end

  assign magic_word = magic_r;

endmodule

FILE: src/kfc_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// KISS frame checker core
// Unescapes one byte per cycle while fire is high, tracks frame state and builds the result.
// ---------------------------------------------------------------------------
module kfc_core
  import kfc_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic [7:0]  rx_byte,
  input  logic [31:0] magic_word,
  output logic        res_valid,
  output result_t     res
);

  localparam int CNT_W = $clog2(BUF_DEPTH + 1);

  logic             escape_r, escape_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [31:0]      magic_r, magic_nxt;
  logic [15:0]      seq_r, seq_nxt;
  logic [31:0]      crc_r, crc_nxt;
  logic [31:0]      tail_r, tail_nxt;
  logic [15:0]      lseq_r, lseq_nxt;

  logic             is_data;
  logic             is_end;
  logic [7:0]       data_byte;
  logic [CNT_W-1:0] diff;
  logic [31:0]      crc_out;

  always_comb begin
    is_data    = 1'b0;
    is_end     = 1'b0;
    data_byte  = rx_byte;
    escape_nxt = escape_r;
    if (escape_r) begin
      escape_nxt = 1'b0;
      is_data    = 1'b1;
      if (rx_byte == KISS_TFEND) begin
        data_byte = KISS_FEND;
      end else if (rx_byte == KISS_TFESC) begin
        data_byte = KISS_FESC;
      end
    end else if (rx_byte == KISS_FESC) begin
      escape_nxt = 1'b1;
    end else if (rx_byte != KISS_FEND) begin
      is_data = 1'b1;
    end else begin
      is_end = 1'b1;
    end
  end

  assign diff    = count_r - CNT_W'(11);
  assign crc_out = ~crc_r;

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    magic_nxt = magic_r;
    seq_nxt   = seq_r;
    crc_nxt   = crc_r;
    tail_nxt  = tail_r;
    lseq_nxt  = lseq_r;
    res_valid = 1'b0;
    res       = '0;
    res.expected_seq = lseq_r;
    if (is_data) begin
      if (32'(count_r) >= BUF_DEPTH) begin
        ovf_nxt = 1'b1;
      end else begin
        if (count_r >= CNT_W'(1) && count_r <= CNT_W'(4)) begin
          magic_nxt = {magic_r[23:0], data_byte};
        end
        if (count_r == CNT_W'(5) || count_r == CNT_W'(6)) begin
          seq_nxt = {seq_r[7:0], data_byte};
        end
        if (count_r >= CNT_W'(9)) begin
          crc_nxt = crc_byte(crc_r, tail_r[31:24]);
        end
        tail_nxt  = {tail_r[23:0], data_byte};
        count_nxt = count_r + CNT_W'(1);
      end
    end else if (is_end) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
      magic_nxt = '0;
      seq_nxt   = '0;
      crc_nxt   = CRC_INIT;
      tail_nxt  = '0;
      if (ovf_r) begin
        res_valid  = 1'b1;
        res.status = ST_OVERFLOW;
      end else if (32'(count_r) >= MIN_FRAME) begin
        res_valid        = 1'b1;
        res.received_seq = seq_r;
        res.computed_crc = crc_out;
        res.received_crc = tail_r;
        if (32'(count_r) < 11) begin
          res.payload_length = '0;
        end else if (32'(diff) > 255) begin
          res.payload_length = '1;
        end else begin
          res.payload_length = PLEN_W'(diff);
        end
        if (magic_r != magic_word) begin
          res.status = ST_BAD_MAGIC;
        end else begin
          res.status = (crc_out == tail_r) ? ST_VALID : ST_CRC_ERR;
          lseq_nxt   = lseq_r + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_r <= 1'b0;
      count_r  <= '0;
      ovf_r    <= 1'b0;
      magic_r  <= '0;
      seq_r    <= '0;
      crc_r    <= CRC_INIT;
      tail_r   <= '0;
      lseq_r   <= 16'd1;
    end else if (fire) begin
      escape_r <= escape_nxt;
      count_r  <= count_nxt;
      ovf_r    <= ovf_nxt;
      magic_r  <= magic_nxt;
      seq_r    <= seq_nxt;
      crc_r    <= crc_nxt;
      tail_r   <= tail_nxt;
      lseq_r   <= lseq_nxt;
    end
  end

endmodule

FILE: src/kiss_frame_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// KISS frame checker
// Deframes a KISS byte stream and checks magic, sequence and CRC-32.
// ---------------------------------------------------------------------------
// Raw radio bytes enter on the input channel (in_valid, in_ready,
// in_rx_byte), one item per cycle while in_ready is high. Each closed
// frame of at least ten bytes gives one item on the result channel;
// shorter frames give nothing, and a frame that overran the buffer gives
// an overflow status. An accepted byte is held in the input register and
// then processed by the core; a frame's result is captured in the result
// register when its closing byte is processed. Throughput is one byte per
// cycle while the receiver does not stall, set by the byte-wide CRC update
// between the two registers.
// When the receiver stalls, a waiting result holds the result register and
// the input register keeps one byte; in_ready drops only when both are
// full. Reset empties both registers, clears all frame state, sets the
// local sequence counter to one and the magic word to its default.
// The magic word is written through the APB-style port at address zero,
// and the user must write it only while the block is idle; no logic enforces it.
// ---------------------------------------------------------------------------
module kiss_frame_checker
  import kfc_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_frame_status,
  output logic [15:0]       out_received_seq,
  output logic [15:0]       out_expected_seq,
  output logic [PLEN_W-1:0] out_payload_length,
  output logic [31:0]       out_computed_crc,
  output logic [31:0]       out_received_crc,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic        in_valid_r;
  logic [7:0]  byte_r;
  logic        out_valid_r;
  result_t     res_r;
  logic        fire;
  logic        res_valid;
  result_t     res;
  logic [31:0] magic_word;

  assign fire     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || fire;

  kfc_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .magic_word (magic_word)
  );

  kfc_core #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .rx_byte    (byte_r),
    .magic_word (magic_word),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_status   = res_r.status;
  assign out_received_seq   = res_r.received_seq;
  assign out_expected_seq   = res_r.expected_seq;
  assign out_payload_length = res_r.payload_length;
  assign out_computed_crc   = res_r.computed_crc;
  assign out_received_crc   = res_r.received_crc;

endmodule

FILE: src/kfc_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// KISS frame checker port checks
// Concurrent checks on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
module kfc_props
  import kfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [1:0]        out_frame_status,
  input  logic [15:0]       out_received_seq,
  input  logic [PLEN_W-1:0] out_payload_length,
  input  logic [31:0]       out_computed_crc,
  input  logic [31:0]       out_received_crc
);

  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_status))
    else $error("result item dropped or changed during a stall");

  a_valid_crc : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_status == ST_VALID |-> out_computed_crc == out_received_crc)
    else $error("valid status with differing CRCs");

  a_bad_crc : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_status == ST_CRC_ERR |-> out_computed_crc != out_received_crc)
    else $error("CRC mismatch status with equal CRCs");

  a_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_status == ST_OVERFLOW |->
      out_received_seq == 16'd0 && out_payload_length == '0 &&
      out_computed_crc == 32'd0 && out_received_crc == 32'd0)
    else $error("overflow item carries frame fields");

endmodule

bind kiss_frame_checker kfc_props u_kfc_props (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_frame_status   (out_frame_status),
  .out_received_seq   (out_received_seq),
  .out_payload_length (out_payload_length),
  .out_computed_crc   (out_computed_crc),
  .out_received_crc   (out_received_crc)
);

FILE: tb/kfc_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// KISS frame checker: scoreboard
// Watches the byte, result and register ports of the frame checker, keeps
// its own deframer, magic comparison, CRC-32 and sequence counter, and
// compares every frame report, field by field, with the oldest prediction.
// Register reads are compared with the magic word last written.
// ---------------------------------------------------------------------------
package kfc_tb_pkg;
  import kfc_pkg::*;

  localparam logic [ADDR_W-1:0] MAGIC_ADDR = ADDR_W'(4 * int'(REG_MAGIC));

  function automatic logic [31:0] crc32_byte(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    c = acc ^ {24'h0, b};
    repeat (8) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction
endpackage

module kfc_checker
  import kfc_pkg::*;
  import kfc_tb_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        in_rx_byte,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [1:0]        out_frame_status,
  input  logic [15:0]       out_received_seq,
  input  logic [15:0]       out_expected_seq,
  input  logic [PLEN_W-1:0] out_payload_length,
  input  logic [31:0]       out_computed_crc,
  input  logic [31:0]       out_received_crc,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic [31:0]       prdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending,
  output int                bytes_seen,
  output int                reports_checked,
  output int                crc_errors,
  output int                magic_errors,
  output int                overflows
);

  result_t     expected_reports[$];
  logic        esc_pending;
  int          frame_len;
  logic        overran;
  logic [31:0] magic_acc;
  logic [15:0] seq_acc;
  logic [31:0] crc_acc;
  logic [31:0] tail_bytes;
  logic [15:0] local_seq;
  logic [31:0] magic_cfg;

  task automatic clear_frame();
    esc_pending = 1'b0;
    frame_len   = 0;
    overran     = 1'b0;
    magic_acc   = '0;
    seq_acc     = '0;
    crc_acc     = CRC_INIT;
    tail_bytes  = '0;
  endtask

  task automatic store_byte(input logic [7:0] b);
    if (frame_len >= BUF_DEPTH) begin
      overran = 1'b1;
    end else begin
      if (frame_len >= 1 && frame_len <= 4) begin
        magic_acc = {magic_acc[23:0], b};
      end
      if (frame_len == 5 || frame_len == 6) begin
        seq_acc = {seq_acc[7:0], b};
      end
      if (frame_len >= 9) begin
        crc_acc = crc32_byte(crc_acc, tail_bytes[31:24]);
      end
      tail_bytes = {tail_bytes[23:0], b};
      frame_len++;
    end
  endtask

  task automatic close_frame();
    result_t r;
    int      plen;
    if (overran) begin
      r.status         = ST_OVERFLOW;
      r.received_seq   = '0;
      r.expected_seq   = local_seq;
      r.payload_length = '0;
      r.computed_crc   = '0;
      r.received_crc   = '0;
      expected_reports.push_back(r);
    end else if (frame_len >= MIN_FRAME) begin
      plen = (frame_len >= 11) ? frame_len - 11 : 0;
      if (plen > 255) begin
        plen = 255;
      end
      r.received_seq   = seq_acc;
      r.expected_seq   = local_seq;
      r.payload_length = PLEN_W'(plen);
      r.computed_crc   = ~crc_acc;
      r.received_crc   = tail_bytes;
      if (magic_acc != magic_cfg) begin
        r.status = ST_BAD_MAGIC;
      end else begin
        if (~crc_acc == tail_bytes) begin
          r.status = ST_VALID;
        end else begin
          r.status = ST_CRC_ERR;
        end
        local_seq = local_seq + 16'd1;
      end
      expected_reports.push_back(r);
    end
    clear_frame();
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    if (esc_pending) begin
      esc_pending = 1'b0;
      if (b == KISS_TFEND) begin
        store_byte(KISS_FEND);
      end else if (b == KISS_TFESC) begin
        store_byte(KISS_FESC);
      end else begin
        store_byte(b);
      end
    end else if (b == KISS_FESC) begin
      esc_pending = 1'b1;
    end else if (b == KISS_FEND) begin
      close_frame();
    end else begin
      store_byte(b);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic compare_report();
    result_t e;
    if (expected_reports.size() == 0) begin
      $error("frame report with no frame closed: status %0d, received_seq %0h",
             out_frame_status, out_received_seq);
      fail_count++;
    end else begin
      e = expected_reports.pop_front();
      check_field("frame_status", 32'(e.status), 32'(out_frame_status));
      check_field("received_seq", 32'(e.received_seq), 32'(out_received_seq));
      check_field("expected_seq", 32'(e.expected_seq), 32'(out_expected_seq));
      check_field("payload_length", 32'(e.payload_length), 32'(out_payload_length));
      check_field("computed_crc", e.computed_crc, out_computed_crc);
      check_field("received_crc", e.received_crc, out_received_crc);
      reports_checked++;
      case (e.status)
        ST_CRC_ERR:   crc_errors++;
        ST_BAD_MAGIC: magic_errors++;
        ST_OVERFLOW:  overflows++;
        default:      ;
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_frame();
      local_seq = 16'd1;
      magic_cfg = MAGIC_RESET;
      expected_reports.delete();
      fail_count      = 0;
      bytes_seen      = 0;
      reports_checked = 0;
      crc_errors      = 0;
      magic_errors    = 0;
      overflows       = 0;
    end else begin
      if (out_valid && out_ready) begin
        compare_report();
      end
      if (in_valid && in_ready) begin
        deframe_byte(in_rx_byte);
        bytes_seen++;
      end
      if (psel && penable && pready && paddr == MAGIC_ADDR) begin
        if (pwrite) begin
          magic_cfg = pwdata;
        end else begin
          check_field("prdata", magic_cfg, prdata);
        end
      end
    end
    pending = expected_reports.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// KISS frame checker: testbench top
// Drives KISS-escaped byte streams into the frame checker: directed frames
// at the length limits and with every escape form, then random frames,
// noise and broken frames under several magic words and idle patterns,
// including a long receiver hold-off. The scoreboard does the checking.
// ---------------------------------------------------------------------------
module tb_top;
  import kfc_pkg::*;
  import kfc_tb_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 10;
  localparam int SETTLE       = 4;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_BYTES  = 80;
  localparam int CYCLE_LIMIT  = 200000;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_valid   = 1'b0;
  logic              in_ready;
  logic [7:0]        in_rx_byte = 8'h00;
  logic              out_valid;
  logic              out_ready  = 1'b0;
  logic [1:0]        out_frame_status;
  logic [15:0]       out_received_seq;
  logic [15:0]       out_expected_seq;
  logic [PLEN_W-1:0] out_payload_length;
  logic [31:0]       out_computed_crc;
  logic [31:0]       out_received_crc;
  logic              psel       = 1'b0;
  logic              penable    = 1'b0;
  logic              pwrite     = 1'b0;
  logic [ADDR_W-1:0] paddr      = '0;
  logic [31:0]       pwdata     = '0;
  logic [31:0]       prdata;
  logic              pready;

  int fail_count;
  int pending;
  int bytes_seen;
  int reports_checked;
  int crc_errors;
  int magic_errors;
  int overflows;

  int          send_idle  = 34;
  int          recv_idle  = 71;
  int          hold_req   = 0;
  int          hold_done  = 0;
  int          hold_left  = 0;
  int          bytes_sent = 0;
  int          cycle_count = 0;
  int          magic_writes = 0;
  logic [31:0] cur_magic  = MAGIC_RESET;
  logic [15:0] tx_seq     = 16'd1;

  always #(CLK_PERIOD / 2) clk = ~clk;

  kiss_frame_checker dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_frame_status   (out_frame_status),
    .out_received_seq   (out_received_seq),
    .out_expected_seq   (out_expected_seq),
    .out_payload_length (out_payload_length),
    .out_computed_crc   (out_computed_crc),
    .out_received_crc   (out_received_crc),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  kfc_checker chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_frame_status   (out_frame_status),
    .out_received_seq   (out_received_seq),
    .out_expected_seq   (out_expected_seq),
    .out_payload_length (out_payload_length),
    .out_computed_crc   (out_computed_crc),
    .out_received_crc   (out_received_crc),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .fail_count         (fail_count),
    .pending            (pending),
    .bytes_seen         (bytes_seen),
    .reports_checked    (reports_checked),
    .crc_errors         (crc_errors),
    .magic_errors       (magic_errors),
    .overflows          (overflows)
  );

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_done) begin
      hold_done <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  function automatic logic [7:0] special_byte(input int idx);
    case (idx % 6)
      0:       return KISS_FEND;
      1:       return KISS_FESC;
      2:       return KISS_TFEND;
      3:       return KISS_TFESC;
      4:       return 8'h00;
      default: return 8'hFF;
    endcase
  endfunction

  function automatic logic [7:0] noisy_byte();
    if ($urandom_range(0, 9) == 0) begin
      return special_byte($urandom_range(0, 5));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_escaped(input logic [7:0] b);
    if (b == KISS_FEND) begin
      send_byte(KISS_FESC);
      send_byte(($urandom_range(0, 3) == 0) ? KISS_FEND : KISS_TFEND);
    end else if (b == KISS_FESC) begin
      send_byte(KISS_FESC);
      send_byte(($urandom_range(0, 3) == 0) ? KISS_FESC : KISS_TFESC);
    end else if (b != KISS_TFEND && b != KISS_TFESC && $urandom_range(0, 15) == 0) begin
      send_byte(KISS_FESC);
      send_byte(b);
    end else begin
      send_byte(b);
    end
  endtask

  task automatic send_frame(input int n_bytes, input bit bad_magic, input bit bad_crc,
                            input logic [15:0] seq, input bit spec);
    logic [7:0]  fr[$];
    logic [7:0]  b;
    logic [31:0] word;
    logic [31:0] crc;
    fr.push_back(noisy_byte());
    word = bad_magic ? cur_magic ^ (32'd1 << $urandom_range(0, 31)) : cur_magic;
    for (int i = 3; i >= 0; i--) fr.push_back(word[8*i +: 8]);
    fr.push_back(seq[15:8]);
    fr.push_back(seq[7:0]);
    crc = crc32_byte(CRC_INIT, seq[15:8]);
    crc = crc32_byte(crc, seq[7:0]);
    for (int i = 0; i < n_bytes - 11; i++) begin
      b = spec ? special_byte(i) : noisy_byte();
      fr.push_back(b);
      crc = crc32_byte(crc, b);
    end
    crc = ~crc;
    if (bad_crc) begin
      crc = crc ^ (32'd1 << $urandom_range(0, 31));
    end
    for (int i = 3; i >= 0; i--) fr.push_back(crc[8*i +: 8]);
    while (fr.size() > n_bytes) void'(fr.pop_back());
    foreach (fr[i]) send_escaped(fr[i]);
    send_byte(KISS_FEND);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 12)) send_byte(noisy_byte());
    send_byte(KISS_FEND);
  endtask

  task automatic random_frame();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      send_noise();
    end else if (r < 12) begin
      send_frame($urandom_range(0, 10), 1'b0, 1'b0, tx_seq, 1'b0);
    end else if (r < 14) begin
      send_frame($urandom_range(240, 270), $urandom_range(0, 9) == 0,
                 $urandom_range(0, 9) == 0, tx_seq, 1'b0);
    end else begin
      send_frame($urandom_range(11, 30), $urandom_range(0, 9) == 0,
                 $urandom_range(0, 6) == 0,
                 ($urandom_range(0, 7) == 0) ? 16'($urandom) : tx_seq, 1'b0);
    end
    tx_seq++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= MAGIC_ADDR;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_magic(input logic [31:0] value);
    drain();
    apb_access(1'b1, value);
    apb_access(1'b0, '0);
    cur_magic = value;
    magic_writes++;
  endtask

  task automatic random_phase(input int s_idle, input int r_idle, input bit hold);
    int start;
    send_idle = s_idle;
    recv_idle <= r_idle;
    if (hold) begin
      hold_req <= hold_req + 1;
    end
    start = bytes_sent;
    while (bytes_sent - start < PHASE_BYTES) random_frame();
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d reports outstanding.", cycle_count, pending);
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(KISS_FEND);
    send_byte(KISS_FEND);
    send_frame(9, 1'b0, 1'b0, 16'h1234, 1'b0);
    send_frame(10, 1'b0, 1'b0, 16'h0000, 1'b0);
    send_frame(11, 1'b0, 1'b0, 16'hFFFF, 1'b0);
    send_frame(23, 1'b0, 1'b0, 16'h0002, 1'b1);
    send_frame(15, 1'b1, 1'b0, 16'h0003, 1'b0);
    send_frame(15, 1'b0, 1'b1, 16'h0004, 1'b0);
    send_frame(15, 1'b1, 1'b1, 16'h0005, 1'b0);
    send_frame(256, 1'b0, 1'b0, 16'h0006, 1'b0);
    send_frame(257, 1'b0, 1'b0, 16'h0007, 1'b0);
    send_byte(KISS_FESC);
    send_byte(8'h00);
    send_byte(KISS_FESC);
    send_byte(KISS_FEND);
    send_byte(KISS_FESC);
    send_byte(KISS_FESC);
    send_byte(KISS_FESC);
    send_byte(KISS_TFEND);
    send_byte(KISS_FESC);
    send_byte(KISS_TFESC);
    repeat (8) send_byte(8'($urandom_range(0, 8'hBF)));
    send_byte(KISS_FEND);
    send_noise();

    set_magic(32'h00000000);
    send_frame(12, 1'b0, 1'b0, 16'h00FF, 1'b0);
    send_frame(12, 1'b1, 1'b0, 16'hFF00, 1'b0);
    set_magic(32'hFFFFFFFF);
    send_frame(14, 1'b0, 1'b0, 16'hFFFF, 1'b0);
    set_magic({KISS_FEND, KISS_FESC, KISS_TFEND, KISS_TFESC});
    send_frame(14, 1'b0, 1'b0, 16'h0009, 1'b0);
    send_frame(14, 1'b1, 1'b0, 16'h000A, 1'b0);

    set_magic($urandom);
    random_phase(34, 71, 1'b0);
    set_magic($urandom);
    random_phase(71, 34, 1'b0);
    set_magic(MAGIC_RESET);
    random_phase(0, 0, 1'b1);
    drain();

    $display("Sent %0d bytes; checked %0d frame reports (%0d CRC errors, %0d bad magic,",
             bytes_seen, reports_checked, crc_errors, magic_errors);
    $display("%0d overflows) across %0d magic word writes and three idle patterns.",
             overflows, magic_writes);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
src/kfc_pkg.sv
src/kfc_cfg.sv
src/kfc_core.sv
src/kiss_frame_checker.sv
src/kfc_checker.sv
tb/kfc_checker.sv
tb/tb_top.sv
